@@ rtl/tcgr_pkg.sv @@
// Shared types and constants for the text console glyph renderer.
`default_nettype none
package tcgr_pkg;

    localparam int SCREEN_W    = 800;
    localparam int SCREEN_H    = 480;
    localparam int GLYPH_BYTES = 4096;
    localparam int MAX_CHAR_W  = 16;

    localparam int GA_W   = $clog2(GLYPH_BYTES);
    localparam int W_CAP  = (MAX_CHAR_W < 16) ? MAX_CHAR_W : 16;
    localparam int H_CAP  = 32;
    localparam int ADDR_W = 19;
    localparam int XY_W   = 12;    // wide enough for cursor sums and screen sizes up to 2048
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    localparam logic [7:0] NEWLINE = 8'h0A;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_CURSOR = 2'd1,
        CMD_DRAW   = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        REG_CHAR_W   = 3'd0,
        REG_CHAR_H   = 3'd1,
        REG_FIRST    = 3'd2,
        REG_FG_COLOR = 3'd3,
        REG_BG_COLOR = 3'd4
    } reg_index_t;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } back_state_t;

    // One queued request for the back part: a font byte store or a glyph draw.
    typedef struct packed {
        logic              is_load;
        logic [GA_W-1:0]   gaddr;       // store address, or glyph start byte
        logic [7:0]        data;
        logic [4:0]        width;       // effective glyph width, 1..16
        logic [5:0]        height;      // effective glyph height, 1..32
        logic [ADDR_W-1:0] start_addr;  // framebuffer word of the top-left pixel
    } job_t;

endpackage
`default_nettype wire

@@ rtl/text_console_glyph_renderer_unit.sv @@
// Top level of the text console glyph renderer: config registers and part hookup.
`default_nettype none
// A request is taken when start is high and busy is low; the front part holds a load
// or draw request in its stage A register until the four-entry queue takes it, and
// stays busy meanwhile. Cursor moves finish in the front part and are never queued.
// A font byte store is written while the back part is idle. A draw of an h-row glyph
// of width w is paced by the glyph memory's single read port, which fetches one font
// byte per cycle while the bit buffer has room. Each row appears on the row ports for
// one cycle with row_valid high and cannot be held off. Glyph memory has no clearing
// pass. Registers are written through cfg_valid/cfg_ready (always ready) and should
// only be written while no request is in progress.
module text_console_glyph_renderer_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  cmd,
    input  wire logic [7:0]  code,
    input  wire logic [11:0] glyph_addr,
    input  wire logic [9:0]  pos_x,
    input  wire logic [8:0]  pos_y,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output logic             row_valid,
    output logic [18:0]      row_address,
    output logic [15:0]      row_bits,
    output logic [31:0]      row_fg,
    output logic [31:0]      row_bg,
    output logic             last
);
    import tcgr_pkg::*;

    logic [4:0]  char_w_reg;
    logic [5:0]  char_h_reg;
    logic [7:0]  first_reg;
    logic [31:0] fg_reg;
    logic [31:0] bg_reg;

    logic        push, q_full, q_not_empty, pop;
    job_t        push_job, head_job;

    assign cfg_ready = 1'b1;
    assign row_fg    = fg_reg;
    assign row_bg    = bg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_w_reg <= 5'd12;
            char_h_reg <= 6'd24;
            first_reg  <= 8'd32;
            fg_reg     <= '0;
            bg_reg     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (reg_index_t'(cfg_index))
                REG_CHAR_W:   char_w_reg <= cfg_data[4:0];
                REG_CHAR_H:   char_h_reg <= cfg_data[5:0];
                REG_FIRST:    first_reg  <= cfg_data[7:0];
                REG_FG_COLOR: fg_reg     <= cfg_data;
                REG_BG_COLOR: bg_reg     <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    tcgr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .code        (code),
        .glyph_addr  (glyph_addr),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .char_width  (char_w_reg),
        .char_height (char_h_reg),
        .first_code  (first_reg),
        .push        (push),
        .push_job    (push_job),
        .q_full      (q_full)
    );

    tcgr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_job  (head_job),
        .pop       (pop)
    );

    tcgr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .head_job    (head_job),
        .pop         (pop),
        .row_valid   (row_valid),
        .row_address (row_address),
        .row_bits    (row_bits),
        .last        (last)
    );

endmodule
`default_nettype wire

@@ rtl/tcgr_front.sv @@
// Front part: takes requests, keeps the cursor, builds draw and font-store jobs for the queue.
`default_nettype none
module tcgr_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [1:0]        cmd,
    input  wire logic [7:0]        code,
    input  wire logic [11:0]       glyph_addr,
    input  wire logic [9:0]        pos_x,
    input  wire logic [8:0]        pos_y,
    input  wire logic [4:0]        char_width,
    input  wire logic [5:0]        char_height,
    input  wire logic [7:0]        first_code,
    output logic                   push,
    output tcgr_pkg::job_t         push_job,
    input  wire logic              q_full
);
    import tcgr_pkg::*;

    logic [9:0]  cur_x_reg, cur_x_next;
    logic [8:0]  cur_y_reg, cur_y_next;
    logic        a_valid_reg, a_valid_next;

    // stage A payload
    logic            a_load_reg;
    logic [7:0]      a_data_reg;
    logic [11:0]     a_gaddr_reg;
    logic [9:0]      a_ox_reg;
    logic [8:0]      a_oy_reg;
    logic [4:0]      a_w_reg;
    logic [5:0]      a_h_reg;
    logic [9:0]      a_wh_reg;
    logic [7:0]      a_idx_reg;

    logic            accept;
    logic [4:0]      eff_w;
    logic [5:0]      eff_h;
    logic [XY_W-1:0] sum_x, sum_y, lim_x, lim_y;
    logic            wrap_x;
    logic [7:0]      draw_code, clamp_code;
    logic [14:0]     base_full;

    assign busy   = a_valid_reg;
    assign accept = start && !a_valid_reg;

    always_comb
    begin
        eff_w = char_width;
        if (char_width == 5'd0)
            eff_w = 5'd1;
        else if (char_width > 5'(W_CAP))
            eff_w = 5'(W_CAP);
        eff_h = char_height;
        if (char_height == 6'd0)
            eff_h = 6'd1;
        else if (char_height > 6'(H_CAP))
            eff_h = 6'(H_CAP);
    end

    // cursor advance
    always_comb
    begin
        lim_x  = XY_W'(SCREEN_W) - XY_W'(eff_w);
        lim_y  = XY_W'(SCREEN_H) - XY_W'(eff_h);
        sum_x  = XY_W'(cur_x_reg) + XY_W'(eff_w);
        wrap_x = (code == NEWLINE) || (sum_x > lim_x);
        sum_y  = wrap_x ? (XY_W'(cur_y_reg) + XY_W'(eff_h)) : XY_W'(cur_y_reg);
        if (sum_y > lim_y)
            sum_y = '0;
        draw_code  = (code == NEWLINE) ? 8'd0 : code;
        clamp_code = (draw_code < first_code) ? first_code : draw_code;
    end

    always_comb
    begin
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        a_valid_next = a_valid_reg;
        if (push)
            a_valid_next = 1'b0;
        if (accept)
        begin
            case (cmd_t'(cmd))
                CMD_LOAD:
                begin
                    a_valid_next = 1'b1;
                end
                CMD_CURSOR:
                begin
                    cur_x_next = pos_x;
                    cur_y_next = pos_y;
                end
                CMD_DRAW:
                begin
                    a_valid_next = 1'b1;
                    cur_x_next   = wrap_x ? 10'd0 : sum_x[9:0];
                    cur_y_next   = sum_y[8:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg   <= '0;
            cur_y_reg   <= '0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            cur_x_reg   <= cur_x_next;
            cur_y_reg   <= cur_y_next;
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_load_reg  <= (cmd_t'(cmd) == CMD_LOAD);
            a_data_reg  <= code;
            a_gaddr_reg <= glyph_addr;
            a_ox_reg    <= cur_x_reg;
            a_oy_reg    <= cur_y_reg;
            a_w_reg     <= eff_w;
            a_h_reg     <= eff_h;
            a_wh_reg    <= 10'(eff_w) * 10'(eff_h);
            a_idx_reg   <= clamp_code - first_code;
        end
    end

    // queue push and job fields: glyph start byte or store address, top-left framebuffer word
    always_comb
    begin
        base_full = 15'(a_wh_reg[9:3]) * 15'(a_idx_reg);
        push      = a_valid_reg && !q_full;
        push_job.is_load    = a_load_reg;
        push_job.gaddr      = a_load_reg ? GA_W'(a_gaddr_reg) : GA_W'(base_full);
        push_job.data       = a_data_reg;
        push_job.width      = a_w_reg;
        push_job.height     = a_h_reg;
        push_job.start_addr = (ADDR_W'(a_oy_reg) * ADDR_W'(SCREEN_W)) + ADDR_W'(a_ox_reg);
    end

endmodule
`default_nettype wire

@@ rtl/tcgr_queue.sv @@
// Small request queue between the front and back parts.
`default_nettype none
module tcgr_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire tcgr_pkg::job_t push_job,
    output logic                full,
    output logic                not_empty,
    output tcgr_pkg::job_t      head_job,
    input  wire logic           pop
);
    import tcgr_pkg::*;

    job_t               entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_PTR_W:0]   count_reg, count_next;

    assign full      = (count_reg == (Q_PTR_W+1)'(Q_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_job  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + Q_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + (Q_PTR_W+1)'(1);
        else if (pop && !push)
            count_next = count_reg - (Q_PTR_W+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule
`default_nettype wire

@@ rtl/tcgr_back.sv @@
// Back part: glyph memory, bit stream fetch and row output.
`default_nettype none
module tcgr_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        q_not_empty,
    input  wire tcgr_pkg::job_t              head_job,
    output logic                             pop,
    output logic                             row_valid,
    output logic [tcgr_pkg::ADDR_W-1:0]      row_address,
    output logic [15:0]                      row_bits,
    output logic                             last
);
    import tcgr_pkg::*;

    logic [7:0]        mem [GLYPH_BYTES];

    back_state_t       state_reg, state_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic [31:0]       buf_reg, buf_next;
    logic              pend_reg, pend_next;
    logic [7:0]        rd_data_reg;
    logic [GA_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [5:0]        rows_left_reg, rows_left_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [4:0]        w_reg, w_next;

    logic              out_valid_reg;
    logic [ADDR_W-1:0] out_addr_reg;
    logic [15:0]       out_bits_reg;
    logic              out_last_reg;

    logic              run, emit, fin, rd_issue, wr_en;
    logic [5:0]        c1;
    logic [31:0]       shifted;

    assign row_valid   = out_valid_reg;
    assign row_address = out_addr_reg;
    assign row_bits    = out_bits_reg;
    assign last        = out_last_reg;

    always_comb
    begin
        run      = (state_reg == BK_RUN);
        emit     = run && (cnt_reg >= {1'b0, w_reg});
        fin      = emit && (rows_left_reg == 6'd1);
        c1       = emit ? cnt_reg - {1'b0, w_reg} : cnt_reg;
        shifted  = emit ? (buf_reg << w_reg) : buf_reg;
        // fetched byte lands right after the bits still held
        buf_next = pend_reg ? (shifted | ({rd_data_reg, 24'd0} >> c1)) : shifted;
        cnt_next = pend_reg ? c1 + 6'd8 : c1;
        rd_issue = run && !fin && (cnt_next <= 6'd24);

        state_next     = state_reg;
        pend_next      = rd_issue;
        rd_ptr_next    = rd_issue ? rd_ptr_reg + GA_W'(1) : rd_ptr_reg;
        rows_left_next = emit ? rows_left_reg - 6'd1 : rows_left_reg;
        addr_next      = emit ? addr_reg + ADDR_W'(SCREEN_W) : addr_reg;
        w_next         = w_reg;
        pop            = 1'b0;
        wr_en          = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                pop = q_not_empty;
                if (q_not_empty)
                begin
                    if (head_job.is_load)
                        wr_en = 1'b1;
                    else
                    begin
                        state_next     = BK_RUN;
                        rd_ptr_next    = head_job.gaddr;
                        rows_left_next = head_job.height;
                        addr_next      = head_job.start_addr;
                        w_next         = head_job.width;
                    end
                end
                buf_next  = '0;
                cnt_next  = '0;
                pend_next = 1'b0;
            end
            BK_RUN:
            begin
                if (fin)
                begin
                    state_next = BK_IDLE;
                    pend_next  = 1'b0;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            rows_left_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            rows_left_reg <= rows_left_next;
            out_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg    <= buf_next;
        rd_ptr_reg <= rd_ptr_next;
        addr_reg   <= addr_next;
        w_reg      <= w_next;
        if (emit)
        begin
            out_addr_reg <= addr_reg;
            out_bits_reg <= buf_reg[31:16] >> (5'd16 - w_reg);
            out_last_reg <= (rows_left_reg == 6'd1);
        end
    end

    // glyph memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[head_job.gaddr] <= head_job.data;
        if (rd_issue)
            rd_data_reg <= mem[rd_ptr_reg];
    end

endmodule
`default_nettype wire

@@ tb/sv/text_console_glyph_renderer_unit_test.sv @@
// Self-checking testbench for the text console glyph renderer: font loads, cursor moves, draws.
module text_console_glyph_renderer_unit_test;
    import tcgr_pkg::*;

    localparam int          HALF_PERIOD = 4;
    localparam int          RESET_CYCLES = 7;
    localparam int          SETTLE_CYCLES = 64;
    localparam int          LIMIT = 1000000;
    localparam int          PHASES = 6;
    localparam int          ITEMS_PER_PHASE = 4;
    localparam int          N_DIR = 39;
    localparam int          FILL_BYTES = 64;
    localparam logic [1:0]  CMD_SPARE = 2'd3;

    typedef struct packed {
        logic [18:0] address;
        logic [15:0] bits;
        logic [31:0] fg;
        logic [31:0] bg;
        logic        last;
    } glyph_row_t;

    typedef struct packed {
        logic        is_cfg;
        logic [2:0]  reg_idx;
        logic [31:0] reg_val;
        logic [1:0]  op;
        logic [7:0]  chr;
        logic [11:0] addr;
        logic [9:0]  x;
        logic [8:0]  y;
        logic        check_first;
        logic [18:0] first_addr;
        logic [15:0] first_bits;
    } step_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  cmd = '0;
    logic [7:0]  code = '0;
    logic [11:0] glyph_addr = '0;
    logic [9:0]  pos_x = '0;
    logic [8:0]  pos_y = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        row_valid;
    logic [18:0] row_address;
    logic [15:0] row_bits;
    logic [31:0] row_fg;
    logic [31:0] row_bg;
    logic        last;

    // shadow copy of the block's state
    logic [7:0]  font_mem [GLYPH_BYTES];
    logic [9:0]  cur_x;
    logic [8:0]  cur_y;
    logic [4:0]  sh_width;
    logic [5:0]  sh_height;
    logic [7:0]  sh_first;
    logic [31:0] sh_fg;
    logic [31:0] sh_bg;

    glyph_row_t  pending_rows [$];
    int          mismatches = 0;
    int          cycle_count = 0;
    bit          no_gaps = 1'b0;
    step_t       dir_steps [N_DIR];

    text_console_glyph_renderer_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .code        (code),
        .glyph_addr  (glyph_addr),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .row_valid   (row_valid),
        .row_address (row_address),
        .row_bits    (row_bits),
        .row_fg      (row_fg),
        .row_bg      (row_bg),
        .last        (last)
    );

    always #(HALF_PERIOD) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // applies one accepted request to the shadow state and queues the rows it draws
    function automatic void predict_glyph_rows(logic [1:0] op, logic [7:0] chr,
                                               logic [11:0] addr, logic [9:0] x,
                                               logic [8:0] y);
        int unsigned w, h, ox, oy, nx, ny, glyph, base, bits, b, fbyte, fb;
        glyph_row_t  r;
        if (op == CMD_LOAD)
        begin
            font_mem[addr] = chr;
            return;
        end
        if (op == CMD_CURSOR)
        begin
            cur_x = x;
            cur_y = y;
            return;
        end
        if (op != CMD_DRAW)
            return;

        w = sh_width;
        if (w < 1) w = 1;
        if (w > W_CAP) w = W_CAP;
        h = sh_height;
        if (h < 1) h = 1;
        if (h > H_CAP) h = H_CAP;
        ox = cur_x;
        oy = cur_y;
        nx = ox;
        ny = oy;
        glyph = chr;
        if (chr == NEWLINE)
        begin
            nx = 0;
            ny = oy + h;
            glyph = 0;
        end
        else
        begin
            nx = ox + w;
            if (nx > SCREEN_W - w)
            begin
                nx = 0;
                ny = oy + h;
            end
        end
        if (ny > SCREEN_H - h)
            ny = 0;
        cur_x = nx[9:0];
        cur_y = ny[8:0];

        if (glyph < sh_first)
            glyph = sh_first;
        base = ((w * h) / 8) * (glyph - sh_first);

        for (int unsigned row = 0; row < h; row++)
        begin
            bits = 0;
            for (int unsigned col = 0; col < w; col++)
            begin
                b = row * w + col;
                fbyte = font_mem[(base + b / 8) % GLYPH_BYTES];
                if (((fbyte << (b % 8)) & 32'h80) != 0)
                    bits |= 32'd1 << (w - 1 - col);
            end
            fb = (oy + row) * SCREEN_W + ox;
            r.address = fb[18:0];
            r.bits = bits[15:0];
            r.fg = sh_fg;
            r.bg = sh_bg;
            r.last = (row + 1 == h);
            pending_rows.push_back(r);
        end
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // one request; a typed first-row address and bits, when given, replace the predicted ones
    task automatic issue(logic [1:0] op, logic [7:0] chr, logic [11:0] addr,
                         logic [9:0] x, logic [8:0] y, logic chk = 1'b0,
                         logic [18:0] faddr = '0, logic [15:0] fbits = '0);
        int unsigned gap;
        int          head;
        start <= 1'b1;
        cmd <= op;
        code <= chr;
        glyph_addr <= addr;
        pos_x <= x;
        pos_y <= y;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        head = pending_rows.size();
        predict_glyph_rows(op, chr, addr, x, y);
        if (chk)
        begin
            pending_rows[head].address = faddr;
            pending_rows[head].bits = fbits;
        end
        gap = pick_gap();
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic set_reg(logic [2:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        case (idx)
            REG_CHAR_W:   sh_width = val[4:0];
            REG_CHAR_H:   sh_height = val[5:0];
            REG_FIRST:    sh_first = val[7:0];
            REG_FG_COLOR: sh_fg = val;
            REG_BG_COLOR: sh_bg = val;
            default:      ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // loads and cursor moves leave no row behind, so give the queue time to empty
    task automatic drain();
        start <= 1'b0;
        while (pending_rows.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic fill_font_memory();
        for (int a = 0; a < FILL_BYTES; a++)
            issue(CMD_LOAD, (a < 16) ? 8'hFF : 8'($urandom), 12'(a), '0, '0);
    endtask

    task automatic random_request();
        int unsigned r, w, h, step, span, top;
        logic [7:0]  chr;
        r = $urandom_range(0, 99);
        if (r < 25)
            issue(CMD_LOAD, 8'($urandom), 12'($urandom), 10'($urandom), 9'($urandom));
        else if (r < 40)
        begin
            if ($urandom_range(0, 3) == 0)
                issue(CMD_CURSOR, 8'($urandom), 12'($urandom), 10'($urandom),
                      9'($urandom));
            else
                issue(CMD_CURSOR, 8'($urandom), 12'($urandom),
                      10'($urandom_range(0, SCREEN_W - 1)),
                      9'($urandom_range(0, SCREEN_H - 1)));
        end
        else if (r < 95)
        begin
            // keep every glyph read inside the filled low bytes of font memory
            w = (sh_width == 5'd0) ? 1 : ((sh_width > W_CAP) ? W_CAP : sh_width);
            h = (sh_height == 6'd0) ? 1 : ((sh_height > H_CAP) ? H_CAP : sh_height);
            step = (w * h) / 8;
            span = (w * h + 7) / 8;
            top = 255 - sh_first;
            if (step != 0 && (FILL_BYTES - span) / step < top)
                top = (FILL_BYTES - span) / step;
            r = $urandom_range(0, 9);
            if (r < 2)
                chr = NEWLINE;
            else if (r < 4)
                chr = 8'($urandom_range(0, sh_first));
            else
                chr = 8'(sh_first + $urandom_range(0, top));
            issue(CMD_DRAW, chr, 12'($urandom), 10'($urandom), 9'($urandom));
        end
        else
            issue(CMD_SPARE, 8'($urandom), 12'($urandom), 10'($urandom), 9'($urandom));
    endtask

    function automatic step_t cfg_row(logic [2:0] idx, logic [31:0] val);
        step_t s;
        s = '0;
        s.is_cfg = 1'b1;
        s.reg_idx = idx;
        s.reg_val = val;
        return s;
    endfunction

    function automatic step_t op_row(logic [1:0] op, logic [7:0] chr, logic [11:0] addr,
                                     logic [9:0] x, logic [8:0] y);
        step_t s;
        s = '0;
        s.op = op;
        s.chr = chr;
        s.addr = addr;
        s.x = x;
        s.y = y;
        return s;
    endfunction

    function automatic step_t chk_row(logic [7:0] chr, logic [18:0] faddr,
                                      logic [15:0] fbits);
        step_t s;
        s = op_row(CMD_DRAW, chr, '0, '0, '0);
        s.check_first = 1'b1;
        s.first_addr = faddr;
        s.first_bits = fbits;
        return s;
    endfunction

    always @(posedge clk)
    begin
        glyph_row_t got, want;
        if (rst_n && row_valid)
        begin
            got = '{row_address, row_bits, row_fg, row_bg, last};
            if (pending_rows.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected row: addr=%0d bits=%h fg=%h bg=%h last=%b",
                             got.address, got.bits, got.fg, got.bg, got.last);
                mismatches++;
            end
            else
            begin
                want = pending_rows.pop_front();
                if (got.address !== want.address || got.bits !== want.bits ||
                    got.fg !== want.fg || got.bg !== want.bg || got.last !== want.last)
                begin
                    if (mismatches < 10)
                        $display({"row mismatch: exp addr=%0d bits=%h fg=%h bg=%h last=%b",
                                  " got addr=%0d bits=%h fg=%h bg=%h last=%b"},
                                 want.address, want.bits, want.fg, want.bg, want.last,
                                 got.address, got.bits, got.fg, got.bg, got.last);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        bit    dirty;
        step_t s;

        cur_x = '0;
        cur_y = '0;
        sh_width = 5'd12;
        sh_height = 6'd24;
        sh_first = 8'd32;
        sh_fg = '0;
        sh_bg = '0;

        // glyph bytes 0..15 are all ones so the top rows of the first glyph read solid
        dir_steps = '{
            chk_row(8'd32, 19'd0, 16'hFFF),
            chk_row(8'd0, 19'd12, 16'hFFF),
            chk_row(NEWLINE, 19'd24, 16'hFFF),
            op_row(CMD_CURSOR, 8'd0, 12'd0, 10'd799, 9'd479),
            chk_row(8'd32, 19'd383999, 16'hFFF),
            op_row(CMD_CURSOR, 8'd0, 12'd0, 10'd1023, 9'd511),
            op_row(CMD_DRAW, 8'd31, 12'd0, 10'd0, 9'd0),
            op_row(CMD_LOAD, 8'h00, 12'd4095, 10'd0, 9'd0),
            op_row(CMD_LOAD, 8'hA5, 12'd2048, 10'd0, 9'd0),
            op_row(CMD_SPARE, 8'd255, 12'd4095, 10'd1023, 9'd511),
            cfg_row(REG_CHAR_W, 32'd16),
            cfg_row(REG_CHAR_H, 32'd32),
            cfg_row(REG_FG_COLOR, 32'hFFFF_FFFF),
            cfg_row(REG_BG_COLOR, 32'd0),
            op_row(CMD_CURSOR, 8'd0, 12'd0, 10'd0, 9'd0),
            chk_row(8'd32, 19'd0, 16'hFFFF),
            op_row(CMD_DRAW, 8'd31, 12'd0, 10'd0, 9'd0),
            cfg_row(REG_CHAR_W, 32'd1),
            cfg_row(REG_CHAR_H, 32'd8),
            op_row(CMD_CURSOR, 8'd0, 12'd0, 10'd0, 9'd0),
            chk_row(8'd32, 19'd0, 16'h1),
            op_row(CMD_DRAW, 8'd95, 12'd0, 10'd0, 9'd0),
            cfg_row(REG_CHAR_W, 32'd0),
            cfg_row(REG_CHAR_H, 32'd0),
            op_row(CMD_DRAW, 8'd200, 12'd0, 10'd0, 9'd0),
            op_row(CMD_DRAW, NEWLINE, 12'd0, 10'd0, 9'd0),
            cfg_row(REG_CHAR_W, 32'd31),
            cfg_row(REG_CHAR_H, 32'd63),
            cfg_row(REG_FIRST, 32'd0),
            op_row(CMD_DRAW, 8'd0, 12'd0, 10'd0, 9'd0),
            op_row(CMD_DRAW, NEWLINE, 12'd0, 10'd0, 9'd0),
            cfg_row(REG_FIRST, 32'd255),
            cfg_row(REG_CHAR_W, 32'd5),
            cfg_row(REG_CHAR_H, 32'd3),
            op_row(CMD_DRAW, 8'd254, 12'd0, 10'd0, 9'd0),
            op_row(CMD_DRAW, 8'd255, 12'd0, 10'd0, 9'd0),
            cfg_row(REG_FG_COLOR, 32'd0),
            cfg_row(REG_BG_COLOR, 32'hFFFF_FFFF),
            op_row(CMD_DRAW, 8'h7F, 12'd0, 10'd0, 9'd0)
        };

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // font memory has no clearing pass; draws only reach the filled low bytes
        fill_font_memory();

        dirty = 1'b1;
        for (int i = 0; i < N_DIR; i++)
        begin
            s = dir_steps[i];
            if (s.is_cfg)
            begin
                if (dirty)
                    drain();
                dirty = 1'b0;
                set_reg(s.reg_idx, s.reg_val);
            end
            else
            begin
                issue(s.op, s.chr, s.addr, s.x, s.y, s.check_first, s.first_addr,
                      s.first_bits);
                dirty = 1'b1;
            end
        end

        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            no_gaps = (p == 1 || p == 4);
            case (p)
                0:
                begin
                    set_reg(REG_CHAR_W, 32'd16);
                    set_reg(REG_CHAR_H, 32'd32);
                    set_reg(REG_FIRST, 32'd0);
                    set_reg(REG_FG_COLOR, 32'hFFFF_FFFF);
                    set_reg(REG_BG_COLOR, 32'd0);
                end
                1:
                begin
                    set_reg(REG_CHAR_W, 32'd1);
                    set_reg(REG_CHAR_H, 32'd1);
                    set_reg(REG_FIRST, 32'd255);
                    set_reg(REG_FG_COLOR, 32'd0);
                    set_reg(REG_BG_COLOR, 32'hFFFF_FFFF);
                end
                default:
                begin
                    set_reg(REG_CHAR_W, $urandom_range(0, 31));
                    set_reg(REG_CHAR_H, $urandom_range(0, 63));
                    set_reg(REG_FIRST, $urandom_range(0, 255));
                    set_reg(REG_FG_COLOR, $urandom);
                    set_reg(REG_BG_COLOR, $urandom);
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                random_request();
        end

        drain();
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
